// File: rtl/core/assert_macros.svh
// assertion macros used by the coverage run merge rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

// File: rtl/core/crm_pkg.sv
// shared types and constants for the coverage run merge
package crm_pkg;

   localparam int MAX_SEGS     = 4;
   localparam int SEG_IDX_BITS = $clog2(MAX_SEGS);
   localparam int SEG_CNT_BITS = $clog2(MAX_SEGS + 1);

   typedef enum logic [0:0] {
      CSR_WINDOW_START = 1'b0,
      CSR_WINDOW_END   = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic                    load;
      logic [SEG_CNT_BITS-1:0] nseg;
   } seg_load_type;

endpackage

// File: rtl/core/crm_merge.sv
// run state and single-pass segment generation for one interval
module crm_merge #(
   parameter int COORD_BITS = 32,
   parameter int COUNT_BITS = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               take,
   input  logic [COORD_BITS-1:0]              window_start,
   input  logic [COORD_BITS-1:0]              window_end,
   input  logic [COORD_BITS-1:0]              read_start,
   input  logic [COORD_BITS-1:0]              read_end,
   input  logic                               last_read,
   input  logic                               no_reads,
   output crm_pkg::seg_load_type              seg_load,
   output logic [COORD_BITS-1:0]              seg_start [crm_pkg::MAX_SEGS],
   output logic [COORD_BITS-1:0]              seg_end   [crm_pkg::MAX_SEGS],
   output logic [COUNT_BITS-1:0]              seg_count [crm_pkg::MAX_SEGS],
   output logic                               seg_last  [crm_pkg::MAX_SEGS]
);
   import crm_pkg::*;

   logic [COORD_BITS-1:0]   run_left_ff, run_left_in;
   logic [COORD_BITS-1:0]   run_right_ff, run_right_in;
   logic [COUNT_BITS-1:0]   run_count_ff, run_count_in;
   logic                    run_open_ff, run_open_in;
   logic                    first_sent_ff, first_sent_in;
   logic [SEG_CNT_BITS-1:0] k;
   logic [COORD_BITS-1:0]   lo;
   logic [COORD_BITS-1:0]   gap_end;

   function automatic logic [COORD_BITS-1:0] clip_lo(
      input logic [COORD_BITS-1:0] s,
      input logic [COORD_BITS-1:0] ws,
      input logic                  en
   );
      return (en && (s < ws)) ? ws : s;
   endfunction

   function automatic logic [COORD_BITS-1:0] clip_hi(
      input logic [COORD_BITS-1:0] s,
      input logic [COORD_BITS-1:0] e,
      input logic [COORD_BITS-1:0] we,
      input logic                  en
   );
      logic [COORD_BITS-1:0] t;
      t = (e > we) ? we : e;
      if (!en) begin
         return e;
      end
      return (t < s) ? s : t;
   endfunction

   always_comb begin
      k             = '0;
      lo            = '0;
      gap_end       = '0;
      run_left_in   = run_left_ff;
      run_right_in  = run_right_ff;
      run_count_in  = run_count_ff;
      run_open_in   = run_open_ff;
      first_sent_in = first_sent_ff;
      for (int i = 0; i < MAX_SEGS; i++) begin
         seg_start[i] = '0;
         seg_end[i]   = '0;
         seg_count[i] = '0;
         seg_last[i]  = 1'b0;
      end

      if (no_reads) begin
         lo                        = clip_lo(window_start, window_start, 1'b1);
         seg_start[k[SEG_IDX_BITS-1:0]] = lo;
         seg_end[k[SEG_IDX_BITS-1:0]]   = clip_hi(lo, window_end, window_end, 1'b1);
         seg_last[k[SEG_IDX_BITS-1:0]]  = 1'b1;
         k                         = k + 1'b1;
         run_left_in               = '0;
         run_right_in              = '0;
         run_count_in              = '0;
         run_open_in               = 1'b0;
         first_sent_in             = 1'b0;
      end else begin
         if (!run_open_ff) begin
            if (window_start < read_start) begin
               lo = clip_lo(window_start, window_start, !first_sent_in);
               seg_start[k[SEG_IDX_BITS-1:0]] = lo;
               seg_end[k[SEG_IDX_BITS-1:0]]   =
                  clip_hi(lo, read_start, window_end, !first_sent_in);
               k             = k + 1'b1;
               first_sent_in = 1'b1;
            end
            run_left_in  = read_start;
            run_right_in = read_end;
            run_count_in = COUNT_BITS'(1);
            run_open_in  = 1'b1;
         end else if ((read_start <= run_right_ff) && (read_end >= run_left_ff)) begin
            if (read_start < run_left_ff) begin
               run_left_in = read_start;
            end
            if (read_end > run_right_ff) begin
               run_right_in = read_end;
            end
            if (run_count_ff != '1) begin
               run_count_in = run_count_ff + 1'b1;
            end
         end else begin
            gap_end = (read_start > run_right_ff) ? read_start : run_right_ff;
            lo = clip_lo(run_left_ff, window_start, !first_sent_in);
            seg_start[k[SEG_IDX_BITS-1:0]] = lo;
            seg_end[k[SEG_IDX_BITS-1:0]]   =
               clip_hi(lo, run_right_ff, window_end, !first_sent_in);
            seg_count[k[SEG_IDX_BITS-1:0]] = run_count_ff;
            k             = k + 1'b1;
            first_sent_in = 1'b1;
            seg_start[k[SEG_IDX_BITS-1:0]] = run_right_ff;
            seg_end[k[SEG_IDX_BITS-1:0]]   = gap_end;
            k             = k + 1'b1;
            run_left_in   = read_start;
            run_right_in  = read_end;
            run_count_in  = COUNT_BITS'(1);
         end

         if (last_read) begin
            if (run_right_in < window_end) begin
               lo = clip_lo(run_left_in, window_start, !first_sent_in);
               seg_start[k[SEG_IDX_BITS-1:0]] = lo;
               seg_end[k[SEG_IDX_BITS-1:0]]   =
                  clip_hi(lo, run_right_in, window_end, !first_sent_in);
               seg_count[k[SEG_IDX_BITS-1:0]] = run_count_in;
               k = k + 1'b1;
               lo = clip_lo(run_right_in, window_start, 1'b1);
               seg_start[k[SEG_IDX_BITS-1:0]] = lo;
               seg_end[k[SEG_IDX_BITS-1:0]]   = clip_hi(lo, window_end, window_end, 1'b1);
               seg_last[k[SEG_IDX_BITS-1:0]]  = 1'b1;
               k = k + 1'b1;
            end else begin
               lo = clip_lo(run_left_in, window_start, 1'b1);
               seg_start[k[SEG_IDX_BITS-1:0]] = lo;
               seg_end[k[SEG_IDX_BITS-1:0]]   = clip_hi(lo, run_right_in, window_end, 1'b1);
               seg_count[k[SEG_IDX_BITS-1:0]] = run_count_in;
               seg_last[k[SEG_IDX_BITS-1:0]]  = 1'b1;
               k = k + 1'b1;
            end
            run_left_in   = '0;
            run_right_in  = '0;
            run_count_in  = '0;
            run_open_in   = 1'b0;
            first_sent_in = 1'b0;
         end
      end
   end

   assign seg_load.load = take;
   assign seg_load.nseg = k;

   always_ff @(posedge clock) begin
      if (reset) begin
         run_open_ff   <= 1'b0;
         first_sent_ff <= 1'b0;
      end else if (take) begin
         run_open_ff   <= run_open_in;
         first_sent_ff <= first_sent_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_left_ff  <= '0;
         run_right_ff <= '0;
         run_count_ff <= '0;
      end else if (take) begin
         run_left_ff  <= run_left_in;
         run_right_ff <= run_right_in;
         run_count_ff <= run_count_in;
      end
   end

endmodule

// File: rtl/core/crm_seg_buffer.sv
// segment queue and result register feeding the rsp channel
`include "assert_macros.svh"

module crm_seg_buffer #(
   parameter int COORD_BITS = 32,
   parameter int COUNT_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  crm_pkg::seg_load_type seg_load,
   input  logic [COORD_BITS-1:0] seg_start [crm_pkg::MAX_SEGS],
   input  logic [COORD_BITS-1:0] seg_end   [crm_pkg::MAX_SEGS],
   input  logic [COUNT_BITS-1:0] seg_count [crm_pkg::MAX_SEGS],
   input  logic                  seg_last  [crm_pkg::MAX_SEGS],
   output logic                  can_load,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [COORD_BITS-1:0] rsp_seg_start,
   output logic [COORD_BITS-1:0] rsp_seg_end,
   output logic [COUNT_BITS-1:0] rsp_merged_count,
   output logic                  rsp_last_segment
);
   import crm_pkg::*;

   logic [COORD_BITS-1:0]   buf_start_ff [MAX_SEGS];
   logic [COORD_BITS-1:0]   buf_end_ff   [MAX_SEGS];
   logic [COUNT_BITS-1:0]   buf_count_ff [MAX_SEGS];
   logic                    buf_last_ff  [MAX_SEGS];
   logic [SEG_CNT_BITS-1:0] cnt_ff, cnt_in;
   logic [SEG_IDX_BITS-1:0] rd_ff, rd_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [COORD_BITS-1:0]   rsp_start_ff;
   logic [COORD_BITS-1:0]   rsp_end_ff;
   logic [COUNT_BITS-1:0]   rsp_count_ff;
   logic                    rsp_last_ff;
   logic                    pop;

   assign pop      = (cnt_ff != '0) && (!rsp_valid_ff || rsp_ready);
   assign can_load = (cnt_ff == '0) || ((cnt_ff == SEG_CNT_BITS'(1)) && pop);

   always_comb begin
      cnt_in       = cnt_ff;
      rd_in        = rd_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (pop) begin
         cnt_in       = cnt_ff - 1'b1;
         rd_in        = rd_ff + 1'b1;
         rsp_valid_in = 1'b1;
      end
      if (seg_load.load) begin
         cnt_in = seg_load.nseg;
         rd_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         rd_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         rd_ff        <= rd_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_start_ff <= buf_start_ff[rd_ff];
         rsp_end_ff   <= buf_end_ff[rd_ff];
         rsp_count_ff <= buf_count_ff[rd_ff];
         rsp_last_ff  <= buf_last_ff[rd_ff];
      end
      if (seg_load.load) begin
         for (int i = 0; i < MAX_SEGS; i++) begin
            buf_start_ff[i] <= seg_start[i];
            buf_end_ff[i]   <= seg_end[i];
            buf_count_ff[i] <= seg_count[i];
            buf_last_ff[i]  <= seg_last[i];
         end
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_seg_start    = rsp_start_ff;
   assign rsp_seg_end      = rsp_end_ff;
   assign rsp_merged_count = rsp_count_ff;
   assign rsp_last_segment = rsp_last_ff;

   `ASSERT_IMPLY(a_load_only_when_free, clock, reset, seg_load.load, can_load, "load while queue busy")
   `ASSERT_ALWAYS(a_cnt_in_range, clock, reset, cnt_ff <= SEG_CNT_BITS'(MAX_SEGS), "queue overfull")
   `ASSERT_ALWAYS(a_rd_cnt_fit, clock, reset, ({1'b0, rd_ff} + cnt_ff) <= SEG_CNT_BITS'(MAX_SEGS), "read index past queue")

endmodule

// File: rtl/core/coverage_run_merge.sv
// an accepted req goes through the item register, segment queue and rsp register
// an interval emits n segments (0 to 4); the queue loads it when empty or popping
// its last segment; the single rsp register sends one segment per cycle unless stalled
// typical sorted input merges most intervals, one interval per cycle while unstalled
// reset: synchronous, clears the window registers, run state and all valid flags
module coverage_run_merge #(
   parameter int COORD_BITS = 32,
   parameter int COUNT_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write_en,
   input  crm_pkg::csr_index_type csr_index,
   input  logic [COORD_BITS-1:0] csr_wdata,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [COORD_BITS-1:0] req_read_start,
   input  logic [COORD_BITS-1:0] req_read_end,
   input  logic                  req_last_read,
   input  logic                  req_no_reads,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [COORD_BITS-1:0] rsp_seg_start,
   output logic [COORD_BITS-1:0] rsp_seg_end,
   output logic [COUNT_BITS-1:0] rsp_merged_count,
   output logic                  rsp_last_segment
);
   import crm_pkg::*;

   logic [COORD_BITS-1:0] window_start_ff;
   logic [COORD_BITS-1:0] window_end_ff;
   logic                  item_valid_ff;
   logic [COORD_BITS-1:0] item_start_ff;
   logic [COORD_BITS-1:0] item_end_ff;
   logic                  item_last_ff;
   logic                  item_none_ff;
   logic                  can_load;
   logic                  take;
   seg_load_type          seg_load;
   logic [COORD_BITS-1:0] seg_start [MAX_SEGS];
   logic [COORD_BITS-1:0] seg_end   [MAX_SEGS];
   logic [COUNT_BITS-1:0] seg_count [MAX_SEGS];
   logic                  seg_last  [MAX_SEGS];

   assign take      = item_valid_ff && can_load;
   assign req_ready = !item_valid_ff || take;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_start_ff <= '0;
         window_end_ff   <= '0;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_WINDOW_START: window_start_ff <= csr_wdata;
            CSR_WINDOW_END:   window_end_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else if (req_ready) begin
         item_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_start_ff <= req_read_start;
         item_end_ff   <= req_read_end;
         item_last_ff  <= req_last_read;
         item_none_ff  <= req_no_reads;
      end
   end

   crm_merge #(
      .COORD_BITS (COORD_BITS),
      .COUNT_BITS (COUNT_BITS)
   ) u_merge (
      .clock        (clock),
      .reset        (reset),
      .take         (take),
      .window_start (window_start_ff),
      .window_end   (window_end_ff),
      .read_start   (item_start_ff),
      .read_end     (item_end_ff),
      .last_read    (item_last_ff),
      .no_reads     (item_none_ff),
      .seg_load     (seg_load),
      .seg_start    (seg_start),
      .seg_end      (seg_end),
      .seg_count    (seg_count),
      .seg_last     (seg_last)
   );

   crm_seg_buffer #(
      .COORD_BITS (COORD_BITS),
      .COUNT_BITS (COUNT_BITS)
   ) u_seg_buffer (
      .clock            (clock),
      .reset            (reset),
      .seg_load         (seg_load),
      .seg_start        (seg_start),
      .seg_end          (seg_end),
      .seg_count        (seg_count),
      .seg_last         (seg_last),
      .can_load         (can_load),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_seg_start    (rsp_seg_start),
      .rsp_seg_end      (rsp_seg_end),
      .rsp_merged_count (rsp_merged_count),
      .rsp_last_segment (rsp_last_segment)
   );

endmodule

// File: bench/tb_coverage_run_merge.sv
// self-checking testbench for coverage_run_merge: interval merge with window gaps
`timescale 1ns / 100ps

module tb_coverage_run_merge;

   localparam int COORD_BITS     = 32;
   localparam int COUNT_BITS     = 16;
   localparam int SETTLE_CYCLES  = 8;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int LONG_RUN_ITEMS = 40;
   localparam int HOLD_CYCLES    = 400;
   localparam int RANDOM_ITEMS   = 320;

   typedef logic [COORD_BITS-1:0] coord_type;
   typedef logic [COUNT_BITS-1:0] count_type;

   localparam coord_type COORD_MAX = '1;
   localparam count_type COUNT_MAX = '1;

   typedef struct packed {
      coord_type seg_start;
      coord_type seg_end;
      count_type merged;
      logic      fin;
   } seg_type;

   logic                   clock            = 1'b0;
   logic                   reset            = 1'b1;
   logic                   csr_write_en     = 1'b0;
   crm_pkg::csr_index_type csr_index        = crm_pkg::CSR_WINDOW_START;
   coord_type              csr_wdata        = '0;
   logic                   req_valid        = 1'b0;
   logic                   req_ready;
   coord_type              req_read_start   = '0;
   coord_type              req_read_end     = '0;
   logic                   req_last_read    = 1'b0;
   logic                   req_no_reads     = 1'b0;
   logic                   rsp_valid;
   logic                   rsp_ready        = 1'b0;
   coord_type              rsp_seg_start;
   coord_type              rsp_seg_end;
   count_type              rsp_merged_count;
   logic                   rsp_last_segment;

   // predictor state
   coord_type win_lo     = '0;
   coord_type win_hi     = '0;
   coord_type run_lo     = '0;
   coord_type run_hi     = '0;
   count_type run_cnt    = '0;
   logic      run_active = 1'b0;
   logic      first_out  = 1'b0;

   seg_type segs_due[$];
   int      mismatch_count = 0;
   int      items_sent     = 0;
   int      quiet_cycles   = 0;
   int      hold_results   = 0;
   bit      req_idle_on    = 1'b1;
   bit      rsp_idle_on    = 1'b1;

   always #2 clock = ~clock;

   coverage_run_merge #(
      .COORD_BITS(COORD_BITS),
      .COUNT_BITS(COUNT_BITS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .csr_write_en(csr_write_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_read_start(req_read_start),
      .req_read_end(req_read_end),
      .req_last_read(req_last_read),
      .req_no_reads(req_no_reads),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_seg_start(rsp_seg_start),
      .rsp_seg_end(rsp_seg_end),
      .rsp_merged_count(rsp_merged_count),
      .rsp_last_segment(rsp_last_segment)
   );

   function automatic int pick_gap(input bit enabled);
      int r;
      if (!enabled) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 94) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic coord_type bump(input coord_type a, input coord_type b);
      return (a > COORD_MAX - b) ? COORD_MAX : a + b;
   endfunction

   // first and last segments of a set are clipped to the window
   function automatic void push_segment(input coord_type s, input coord_type e,
                                        input count_type c, input logic fin);
      seg_type seg;
      if (!first_out || fin) begin
         if (s < win_lo) s = win_lo;
         if (e > win_hi) e = win_hi;
         if (e < s) e = s;
      end
      seg.seg_start = s;
      seg.seg_end   = e;
      seg.merged    = c;
      seg.fin       = fin;
      segs_due.insert(segs_due.size(), seg);
      first_out = 1'b1;
   endfunction

   function automatic void close_set();
      run_lo     = '0;
      run_hi     = '0;
      run_cnt    = '0;
      run_active = 1'b0;
      first_out  = 1'b0;
   endfunction

   function automatic void predict_segments(input coord_type rs, input coord_type re,
                                            input logic lr, input logic nr);
      coord_type gap_hi;
      if (nr) begin
         push_segment(win_lo, win_hi, '0, 1'b1);
         close_set();
         return;
      end
      if (!run_active) begin
         if (win_lo < rs) push_segment(win_lo, rs, '0, 1'b0);
         run_lo     = rs;
         run_hi     = re;
         run_cnt    = 1;
         run_active = 1'b1;
      end else if (rs <= run_hi && re >= run_lo) begin
         if (rs < run_lo) run_lo = rs;
         if (re > run_hi) run_hi = re;
         if (run_cnt != COUNT_MAX) run_cnt = run_cnt + 1'b1;
      end else begin
         gap_hi = (rs > run_hi) ? rs : run_hi;
         push_segment(run_lo, run_hi, run_cnt, 1'b0);
         push_segment(run_hi, gap_hi, '0, 1'b0);
         run_lo  = rs;
         run_hi  = re;
         run_cnt = 1;
      end
      if (lr) begin
         if (run_hi < win_hi) begin
            push_segment(run_lo, run_hi, run_cnt, 1'b0);
            push_segment(run_hi, win_hi, '0, 1'b1);
         end else begin
            push_segment(run_lo, run_hi, run_cnt, 1'b1);
         end
         close_set();
      end
   endfunction

   task automatic report_mismatch(input string msg);
      if (mismatch_count < 100) $display("mismatch at %0t: %s", $time, msg);
      mismatch_count++;
   endtask

   task automatic send_interval(input coord_type rs, input coord_type re, input logic lr,
                                input logic nr);
      int pause;
      pause = pick_gap(req_idle_on);
      if (pause > 0) begin
         req_valid <= 1'b0;
         repeat (pause) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_read_start <= rs;
      req_read_end   <= re;
      req_last_read  <= lr;
      req_no_reads   <= nr;
      do @(posedge clock); while (!req_ready);
      predict_segments(rs, re, lr, nr);
      items_sent++;
   endtask

   // wait for every expected transaction, then let in-flight merges finish
   task automatic settle();
      req_valid <= 1'b0;
      while (segs_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_window(input coord_type lo, input coord_type hi);
      csr_write_en <= 1'b1;
      csr_index    <= crm_pkg::CSR_WINDOW_START;
      csr_wdata    <= lo;
      @(posedge clock);
      csr_index    <= crm_pkg::CSR_WINDOW_END;
      csr_wdata    <= hi;
      @(posedge clock);
      csr_write_en <= 1'b0;
      win_lo = lo;
      win_hi = hi;
   endtask

   task automatic test_reset_window();
      settle();
      send_interval(32'd0, 32'd0, 1'b0, 1'b1);
      send_interval(32'd5, 32'd10, 1'b1, 1'b0);
   endtask

   task automatic test_window_gaps();
      settle();
      write_window(32'd100, 32'd1000);
      send_interval(32'd150, 32'd200, 1'b0, 1'b0);
      send_interval(32'd180, 32'd250, 1'b0, 1'b0);
      send_interval(32'd250, 32'd300, 1'b0, 1'b0);
      send_interval(32'd400, 32'd500, 1'b0, 1'b0);
      send_interval(32'd600, 32'd700, 1'b1, 1'b0);
   endtask

   task automatic test_touch_left_and_clip();
      settle();
      write_window(32'd1000, 32'd2000);
      send_interval(32'd900, 32'd1100, 1'b0, 1'b0);
      send_interval(32'd1100, 32'd1200, 1'b0, 1'b0);
      send_interval(32'd800, 32'd900, 1'b0, 1'b0);
      send_interval(32'd1500, 32'd2500, 1'b1, 1'b0);
   endtask

   task automatic test_coordinate_extremes();
      settle();
      write_window('0, COORD_MAX);
      send_interval('0, 32'd1, 1'b0, 1'b0);
      send_interval(COORD_MAX - 1, COORD_MAX, 1'b1, 1'b0);
      settle();
      write_window(COORD_MAX, COORD_MAX);
      send_interval(COORD_MAX, '0, 1'b1, 1'b0);
   endtask

   task automatic test_inverted_window();
      settle();
      write_window(32'd500, 32'd100);
      send_interval(32'd200, 32'd300, 1'b0, 1'b0);
      send_interval(32'd400, 32'd450, 1'b1, 1'b0);
   endtask

   task automatic test_unsorted_run();
      settle();
      write_window('0, 32'd1000);
      send_interval(32'd500, 32'd600, 1'b0, 1'b0);
      send_interval(32'd100, 32'd200, 1'b0, 1'b0);
      send_interval(32'd150, 32'd160, 1'b1, 1'b0);
   endtask

   task automatic test_inverted_interval();
      settle();
      send_interval(32'd300, 32'd250, 1'b0, 1'b0);
      send_interval(32'd260, 32'd400, 1'b1, 1'b0);
   endtask

   task automatic test_no_reads_open_run();
      settle();
      write_window(32'd10, 32'd90);
      send_interval(32'd20, 32'd30, 1'b0, 1'b0);
      send_interval(32'd40, 32'd50, 1'b0, 1'b0);
      send_interval('0, '0, 1'b0, 1'b1);
      send_interval(COORD_MAX, COORD_MAX, 1'b1, 1'b1);
   endtask

   // many intervals merged back to back into one run
   task automatic test_long_run();
      int i;
      settle();
      write_window('0, 32'd100);
      req_idle_on = 1'b0;
      for (i = 0; i < LONG_RUN_ITEMS; i++)
         send_interval(32'd10, 32'd20, i == LONG_RUN_ITEMS - 1, 1'b0);
      req_idle_on = 1'b1;
   endtask

   // block fills up behind a long result stall while intervals keep coming
   task automatic test_result_hold();
      int i;
      coord_type rs;
      settle();
      write_window('0, 32'd10000);
      req_idle_on  = 1'b0;
      hold_results = HOLD_CYCLES;
      for (i = 0; i < 24; i++) begin
         rs = 100 + i * 100;
         send_interval(rs, rs + 50, i == 23, 1'b0);
      end
      req_idle_on = 1'b1;
   endtask

   task automatic test_random_sets(input int target);
      int        goal, n, kind, i;
      coord_type lo, hi, cur, rs, re;
      logic      lr, nr;
      goal = items_sent + target;
      while (items_sent < goal) begin
         settle();
         if ($urandom_range(0, 2) == 0) begin
            case ($urandom_range(0, 5))
               0: begin
                  lo = '0;
                  hi = $urandom_range(0, 3000);
               end
               1: begin
                  lo = COORD_MAX - $urandom_range(0, 3000);
                  hi = COORD_MAX;
               end
               2: begin
                  lo = '0;
                  hi = COORD_MAX;
               end
               3: begin
                  hi = $urandom_range(0, 32'hFFFF_0000);
                  lo = hi + $urandom_range(1, 500);
               end
               4: begin
                  lo = $urandom();
                  hi = $urandom();
               end
               default: begin
                  lo = $urandom_range(0, 32'hFFFF_0000);
                  hi = lo + $urandom_range(0, 3000);
               end
            endcase
            write_window(lo, hi);
         end
         req_idle_on = ($urandom_range(0, 3) != 0);
         rsp_idle_on = ($urandom_range(0, 3) != 0);
         kind = $urandom_range(0, 19);
         n    = $urandom_range(1, 12);
         cur  = (win_lo > 50) ? win_lo - $urandom_range(0, 50) : $urandom_range(0, 50);
         for (i = 0; i < n; i++) begin
            lr = (i == n - 1);
            nr = 1'b0;
            if (kind == 0) begin
               rs = $urandom();
               re = $urandom();
               nr = ($urandom_range(0, 7) == 0);
               lr = lr | ($urandom_range(0, 3) == 0);
            end else begin
               rs = bump(cur, ($urandom_range(0, 3) == 0) ? $urandom_range(0, 400)
                                                           : $urandom_range(0, 25));
               re = bump(rs, $urandom_range(0, 60));
               case ($urandom_range(0, 31))
                  0: re = rs - $urandom_range(1, 20);
                  1: rs = cur - $urandom_range(1, 300);
                  2: nr = 1'b1;
                  3: settle();
                  4: re = bump(rs, $urandom_range(1000, 5000));
                  default: ;
               endcase
               cur = rs;
            end
            send_interval(rs, re, lr, nr);
            if (nr) break;
         end
      end
   endtask

   initial begin : result_sink
      int stall;
      forever begin
         @(posedge clock);
         if (hold_results > 0) begin
            stall        = hold_results;
            hold_results = 0;
         end else begin
            stall = pick_gap(rsp_idle_on);
         end
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin : check_segments
      seg_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (segs_due.size() == 0) begin
            report_mismatch($sformatf("unexpected transaction [%0h,%0h) count %0d last %0b",
                            rsp_seg_start, rsp_seg_end, rsp_merged_count, rsp_last_segment));
         end else begin
            want = segs_due.pop_front();
            if (rsp_seg_start !== want.seg_start)
               report_mismatch($sformatf("seg_start got %0h want %0h",
                               rsp_seg_start, want.seg_start));
            if (rsp_seg_end !== want.seg_end)
               report_mismatch($sformatf("seg_end got %0h want %0h",
                               rsp_seg_end, want.seg_end));
            if (rsp_merged_count !== want.merged)
               report_mismatch($sformatf("merged_count got %0d want %0d",
                               rsp_merged_count, want.merged));
            if (rsp_last_segment !== want.fin)
               report_mismatch($sformatf("last_segment got %0b want %0b",
                               rsp_last_segment, want.fin));
         end
      end
   end

   always @(posedge clock) begin : watchdog
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("tb_coverage_run_merge: done, errors");
         $finish;
      end
   end

   initial begin : stimulus
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      test_reset_window();
      test_window_gaps();
      test_touch_left_and_clip();
      test_coordinate_extremes();
      test_inverted_window();
      test_unsorted_run();
      test_inverted_interval();
      test_no_reads_open_run();
      test_long_run();
      test_result_hold();
      test_random_sets(RANDOM_ITEMS);
      settle();
      if (mismatch_count == 0 && segs_due.size() == 0)
         $display("tb_coverage_run_merge: done, clean");
      else
         $display("tb_coverage_run_merge: done, errors");
      $finish;
   end

endmodule

// File: coverage_run_merge.f
+incdir+rtl/core
rtl/core/crm_pkg.sv
rtl/core/crm_merge.sv
rtl/core/crm_seg_buffer.sv
rtl/core/coverage_run_merge.sv
bench/tb_coverage_run_merge.sv
